FILE: rtl/branch_stretch_harmonic_force_unit_defines.svh
// Assertion macros used by the checker module.
`ifndef BRANCH_STRETCH_HARMONIC_FORCE_UNIT_DEFINES_SVH
`define BRANCH_STRETCH_HARMONIC_FORCE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSHF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSHF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bshf_pkg.sv
package bshf_pkg;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [47:0] SMAX48 = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SMIN48 = {1'b1, {47{1'b0}}};
  localparam logic [47:0] UMAX48 = {48{1'b1}};
  localparam int SQRT_STAGES = 33;
  localparam int DIV_STAGES = 31;

  typedef struct packed {
    logic [2:0][32:0] d;
    logic [16:0] p;
    logic [16:0] wa;
    logic [31:0] k;
    logic [30:0] l0;
  } bshf_geo_t;

  typedef struct packed {
    logic zero;
    logic [2:0] dneg;
    logic [16:0] p;
    logic [16:0] wa;
  } bshf_ctl_t;

  function automatic logic signed [47:0] sat_s48(input logic [63:0] mag, input logic neg);
    logic signed [47:0] r;
    if (neg) begin
      if (mag >= 64'h0000_8000_0000_0000) r = SMIN48;
      else r = -$signed(mag[47:0]);
    end else begin
      if (mag > 64'h0000_7FFF_FFFF_FFFF) r = SMAX48;
      else r = $signed(mag[47:0]);
    end
    return r;
  endfunction

  function automatic logic [47:0] abs48(input logic signed [47:0] v);
    logic [47:0] r;
    if (v[47]) r = 48'(-v);
    else r = v;
    return r;
  endfunction

endpackage

FILE: rtl/bshf_front.sv
module bshf_front import bshf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic             in_v,
  input  logic [2:0][31:0] a,
  input  logic [2:0][31:0] b,
  input  logic [2:0][31:0] c,
  input  logic [16:0]      bpos,
  input  logic [31:0]      k,
  input  logic [30:0]      l0,
  output logic             out_v,
  output logic [65:0]      sum,
  output bshf_geo_t        geo
);

  logic [16:0] p_c;
  logic [16:0] wa_c;
  logic signed [49:0] pa_c [3];
  logic signed [49:0] pb_c [3];

  logic s1_v;
  logic signed [49:0] s1_pa [3];
  logic signed [49:0] s1_pb [3];
  logic [2:0][31:0] s1_c;
  logic [16:0] s1_p;
  logic [16:0] s1_wa;
  logic [31:0] s1_k;
  logic [30:0] s1_l0;

  logic signed [50:0] num_c [3];
  logic signed [50:0] rnd_c [3];
  bshf_geo_t geo_c;

  logic s2_v;
  bshf_geo_t s2_geo;

  logic [32:0] m_c [3];
  logic s3_v;
  logic [65:0] s3_sq [3];
  bshf_geo_t s3_geo;

  always_comb begin
    p_c = (bpos > ONE_Q16) ? ONE_Q16 : bpos;
    wa_c = ONE_Q16 - p_c;
    for (int i = 0; i < 3; i++) begin
      pa_c[i] = $signed({1'b0, wa_c}) * $signed(a[i]);
      pb_c[i] = $signed({1'b0, p_c}) * $signed(b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (ce) s1_v <= in_v;
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s1_pa[i] <= pa_c[i];
        s1_pb[i] <= pb_c[i];
      end
      s1_c <= c;
      s1_p <= p_c;
      s1_wa <= wa_c;
      s1_k <= k;
      s1_l0 <= l0;
    end
  end

  always_comb begin
    geo_c.p = s1_p;
    geo_c.wa = s1_wa;
    geo_c.k = s1_k;
    geo_c.l0 = s1_l0;
    for (int i = 0; i < 3; i++) begin
      num_c[i] = $signed({{3{s1_c[i][31]}}, s1_c[i], 16'b0})
                 - (51'(s1_pa[i]) + 51'(s1_pb[i]));
      rnd_c[i] = num_c[i] + 51'sd32768;
      geo_c.d[i] = rnd_c[i][48:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (ce) s2_v <= s1_v;
    if (ce) s2_geo <= geo_c;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_c[i] = s2_geo.d[i][32] ? 33'(-s2_geo.d[i]) : s2_geo.d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (ce) s3_v <= s2_v;
    if (ce) begin
      for (int i = 0; i < 3; i++) s3_sq[i] <= 66'(m_c[i]) * 66'(m_c[i]);
      s3_geo <= s2_geo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (ce) out_v <= s3_v;
    if (ce) begin
      sum <= s3_sq[0] + s3_sq[1] + s3_sq[2];
      geo <= s3_geo;
    end
  end

endmodule

FILE: rtl/bshf_sqrt.sv
module bshf_sqrt import bshf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        ce,
  input  logic        in_v,
  input  logic [65:0] rad,
  input  bshf_geo_t   in_geo,
  output logic        out_v,
  output logic [32:0] len,
  output bshf_geo_t   out_geo
);

  logic        v_q    [SQRT_STAGES];
  logic [35:0] rem_q  [SQRT_STAGES];
  logic [32:0] root_q [SQRT_STAGES];
  logic [65:0] x_q    [SQRT_STAGES];
  bshf_geo_t   g_q    [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    logic        pv;
    logic [35:0] prem;
    logic [32:0] proot;
    logic [65:0] px;
    bshf_geo_t   pg;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    if (j == 0) begin : g_first
      assign pv = in_v;
      assign prem = '0;
      assign proot = '0;
      assign px = rad;
      assign pg = in_geo;
    end else begin : g_rest
      assign pv = v_q[j-1];
      assign prem = rem_q[j-1];
      assign proot = root_q[j-1];
      assign px = x_q[j-1];
      assign pg = g_q[j-1];
    end

    always_comb begin
      rem_sh = {prem[33:0], px[2*(SQRT_STAGES-1-j)+1 -: 2]};
      trial = {1'b0, proot, 2'b01};
      ge = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) v_q[j] <= 1'b0;
      else if (ce) v_q[j] <= pv;
      if (ce) begin
        rem_q[j] <= ge ? (rem_sh - trial) : rem_sh;
        root_q[j] <= {proot[31:0], ge};
        x_q[j] <= px;
        g_q[j] <= pg;
      end
    end
  end

  assign out_v = v_q[SQRT_STAGES-1];
  assign len = root_q[SQRT_STAGES-1];
  assign out_geo = g_q[SQRT_STAGES-1];

endmodule

FILE: rtl/bshf_div.sv
module bshf_div import bshf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic             in_v,
  input  logic [32:0]      in_len,
  input  bshf_geo_t        in_geo,
  output logic             out_v,
  output logic [32:0]      out_len,
  output logic [2:0][30:0] u,
  output bshf_geo_t        out_geo
);

  logic             pre_v;
  logic [2:0][63:0] pre_rem;
  logic [32:0]      pre_len;
  bshf_geo_t        pre_geo;
  logic [32:0]      m_c [3];

  logic             v_q   [DIV_STAGES];
  logic [2:0][63:0] rem_q [DIV_STAGES];
  logic [2:0][30:0] q_q   [DIV_STAGES];
  logic [32:0]      len_q [DIV_STAGES];
  bshf_geo_t        g_q   [DIV_STAGES];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_c[i] = in_geo.d[i][32] ? 33'(-in_geo.d[i]) : in_geo.d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pre_v <= 1'b0;
    else if (ce) pre_v <= in_v;
    if (ce) begin
      for (int i = 0; i < 3; i++) pre_rem[i] <= {1'b0, m_c[i], 30'b0};
      pre_len <= in_len;
      pre_geo <= in_geo;
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic             pv;
    logic [2:0][63:0] prem;
    logic [2:0][30:0] pq;
    logic [32:0]      plen;
    bshf_geo_t        pg;
    logic [63:0]      dv;
    logic [2:0][63:0] rem_c;
    logic [2:0][30:0] q_c;

    if (j == 0) begin : g_first
      assign pv = pre_v;
      assign prem = pre_rem;
      assign pq = '0;
      assign plen = pre_len;
      assign pg = pre_geo;
    end else begin : g_rest
      assign pv = v_q[j-1];
      assign prem = rem_q[j-1];
      assign pq = q_q[j-1];
      assign plen = len_q[j-1];
      assign pg = g_q[j-1];
    end

    always_comb begin
      dv = {31'b0, plen} << (DIV_STAGES - 1 - j);
      for (int i = 0; i < 3; i++) begin
        if (prem[i] >= dv) begin
          rem_c[i] = prem[i] - dv;
          q_c[i] = {pq[i][29:0], 1'b1};
        end else begin
          rem_c[i] = prem[i];
          q_c[i] = {pq[i][29:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) v_q[j] <= 1'b0;
      else if (ce) v_q[j] <= pv;
      if (ce) begin
        rem_q[j] <= rem_c;
        q_q[j] <= q_c;
        len_q[j] <= plen;
        g_q[j] <= pg;
      end
    end
  end

  assign out_v = v_q[DIV_STAGES-1];
  assign out_len = len_q[DIV_STAGES-1];
  assign u = q_q[DIV_STAGES-1];
  assign out_geo = g_q[DIV_STAGES-1];

endmodule

FILE: rtl/bshf_back.sv
module bshf_back import bshf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic             in_v,
  input  logic [32:0]      len,
  input  logic [2:0][30:0] u,
  input  bshf_geo_t        geo,
  output logic             out_v,
  output logic [2:0][47:0] fa,
  output logic [2:0][47:0] fb,
  output logic [2:0][47:0] fc,
  output logic [47:0]      energy,
  output logic [47:0]      tension,
  output logic             zero
);

  logic signed [34:0] s_c;
  bshf_ctl_t ctl_c;

  logic b1_v, b1_sneg;
  logic [33:0] b1_ms;
  logic [31:0] b1_k;
  logic [2:0][30:0] b1_u;
  bshf_ctl_t b1_ctl;

  logic b2_v, b2_sneg;
  logic [65:0] b2_p1;
  logic [33:0] b2_ms;
  logic [2:0][30:0] b2_u;
  bshf_ctl_t b2_ctl;

  logic [66:0] tr_c;
  logic b3_v;
  logic signed [47:0] b3_t;
  logic [67:0] b3_e1;
  logic [65:0] b3_e2;
  logic [2:0][30:0] b3_u;
  bshf_ctl_t b3_ctl;

  logic [47:0] tm_c;
  logic b4_v;
  logic [99:0] b4_ef;
  logic [2:0][54:0] b4_gl;
  logic [2:0][54:0] b4_gh;
  logic [2:0] b4_gneg;
  logic signed [47:0] b4_t;
  bshf_ctl_t b4_ctl;

  logic [100:0] er_c;
  logic [67:0] emag_c;
  logic b5_v;
  logic [47:0] b5_e;
  logic [2:0][78:0] b5_gf;
  logic [2:0] b5_gneg;
  logic signed [47:0] b5_t;
  bshf_ctl_t b5_ctl;

  logic [79:0] gr_c [3];
  logic b6_v;
  logic [2:0][47:0] b6_g;
  logic [47:0] b6_e;
  logic signed [47:0] b6_t;
  bshf_ctl_t b6_ctl;

  logic [47:0] gm_c [3];
  logic b7_v;
  logic [2:0][64:0] b7_pa;
  logic [2:0][64:0] b7_pb;
  logic [2:0][47:0] b7_fc;
  logic [2:0] b7_gn;
  logic [47:0] b7_e;
  logic signed [47:0] b7_t;
  bshf_ctl_t b7_ctl;

  logic [65:0] ra_c [3];
  logic [65:0] rb_c [3];

  always_comb begin
    s_c = $signed({2'b0, len}) - $signed({4'b0, geo.l0});
    ctl_c.zero = (len == '0);
    ctl_c.p = geo.p;
    ctl_c.wa = geo.wa;
    for (int i = 0; i < 3; i++) ctl_c.dneg[i] = geo.d[i][32];
  end

  always_ff @(posedge clk) begin
    if (rst) b1_v <= 1'b0;
    else if (ce) b1_v <= in_v;
    if (ce) begin
      b1_sneg <= s_c[34];
      b1_ms <= s_c[34] ? 34'(-s_c) : 34'(s_c);
      b1_k <= geo.k;
      b1_u <= u;
      b1_ctl <= ctl_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b2_v <= 1'b0;
    else if (ce) b2_v <= b1_v;
    if (ce) begin
      b2_p1 <= 66'(b1_k) * 66'(b1_ms);
      b2_ms <= b1_ms;
      b2_sneg <= b1_sneg;
      b2_u <= b1_u;
      b2_ctl <= b1_ctl;
    end
  end

  assign tr_c = 67'(b2_p1) + 67'd32768;

  always_ff @(posedge clk) begin
    if (rst) b3_v <= 1'b0;
    else if (ce) b3_v <= b2_v;
    if (ce) begin
      b3_t <= sat_s48(64'(tr_c[66:16]), b2_sneg);
      b3_e1 <= 68'(b2_p1[33:0]) * 68'(b2_ms);
      b3_e2 <= 66'(b2_p1[65:34]) * 66'(b2_ms);
      b3_u <= b2_u;
      b3_ctl <= b2_ctl;
    end
  end

  assign tm_c = abs48(b3_t);

  always_ff @(posedge clk) begin
    if (rst) b4_v <= 1'b0;
    else if (ce) b4_v <= b3_v;
    if (ce) begin
      b4_ef <= {b3_e2, 34'b0} + 100'(b3_e1);
      for (int i = 0; i < 3; i++) begin
        b4_gl[i] <= 55'(tm_c[23:0]) * 55'(b3_u[i]);
        b4_gh[i] <= 55'(tm_c[47:24]) * 55'(b3_u[i]);
        b4_gneg[i] <= b3_t[47] ^ b3_ctl.dneg[i];
      end
      b4_t <= b3_t;
      b4_ctl <= b3_ctl;
    end
  end

  always_comb begin
    er_c = 101'(b4_ef) + (101'd1 << 32);
    emag_c = er_c[100:33];
  end

  always_ff @(posedge clk) begin
    if (rst) b5_v <= 1'b0;
    else if (ce) b5_v <= b4_v;
    if (ce) begin
      b5_e <= (emag_c > 68'(UMAX48)) ? UMAX48 : emag_c[47:0];
      for (int i = 0; i < 3; i++) b5_gf[i] <= {b4_gh[i], 24'b0} + 79'(b4_gl[i]);
      b5_gneg <= b4_gneg;
      b5_t <= b4_t;
      b5_ctl <= b4_ctl;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) gr_c[i] = 80'(b5_gf[i]) + (80'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (rst) b6_v <= 1'b0;
    else if (ce) b6_v <= b5_v;
    if (ce) begin
      for (int i = 0; i < 3; i++) b6_g[i] <= sat_s48(64'(gr_c[i][79:30]), b5_gneg[i]);
      b6_e <= b5_e;
      b6_t <= b5_t;
      b6_ctl <= b5_ctl;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) gm_c[i] = abs48(b6_g[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) b7_v <= 1'b0;
    else if (ce) b7_v <= b6_v;
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        b7_pa[i] <= 65'(gm_c[i]) * 65'(b6_ctl.wa);
        b7_pb[i] <= 65'(gm_c[i]) * 65'(b6_ctl.p);
        b7_fc[i] <= ($signed(b6_g[i]) == SMIN48) ? SMAX48 : 48'(-$signed(b6_g[i]));
        b7_gn[i] <= b6_g[i][47];
      end
      b7_e <= b6_e;
      b7_t <= b6_t;
      b7_ctl <= b6_ctl;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ra_c[i] = 66'(b7_pa[i]) + 66'd32768;
      rb_c[i] = 66'(b7_pb[i]) + 66'd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (ce) out_v <= b7_v;
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (b7_ctl.zero) begin
          fa[i] <= '0;
          fb[i] <= '0;
          fc[i] <= '0;
        end else begin
          fa[i] <= sat_s48(64'(ra_c[i][65:16]), b7_gn[i]);
          fb[i] <= sat_s48(64'(rb_c[i][65:16]), b7_gn[i]);
          fc[i] <= b7_fc[i];
        end
      end
      energy <= b7_e;
      tension <= b7_t;
      zero <= b7_ctl.zero;
    end
  end

endmodule

FILE: rtl/branch_stretch_harmonic_force_unit.sv
// Branch stretching spring, harmonic, in Q.16 fixed point.
// Input channel: in_valid with in_stall. One transfer carries three bead
// positions, the fraction along segment A-B, the stiffness and the rest length.
// Output channel: out_valid with out_stall. One transfer carries the nine force
// increments, the spring energy, the tension and the zero length flag.
// Every input transfer yields exactly one output transfer, in order.
// An input transfer passes in order through geometry and squares, the square
// root (one result bit per stage), the three unit vector dividers (one
// quotient bit per stage), and the tension, energy and force products.
// Throughput is one item per cycle while no result waits on out_stall.
// When a result waits on out_stall, the whole pipeline holds and in_stall is
// raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits, so out_valid is low after reset.
module branch_stretch_harmonic_force_unit import bshf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] bead_a_x,
  input  logic [31:0] bead_a_y,
  input  logic [31:0] bead_a_z,
  input  logic [31:0] bead_b_x,
  input  logic [31:0] bead_b_y,
  input  logic [31:0] bead_b_z,
  input  logic [31:0] bead_c_x,
  input  logic [31:0] bead_c_y,
  input  logic [31:0] bead_c_z,
  input  logic [16:0] branch_position,
  input  logic [31:0] stiffness,
  input  logic [30:0] rest_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] force_a_x,
  output logic [47:0] force_a_y,
  output logic [47:0] force_a_z,
  output logic [47:0] force_b_x,
  output logic [47:0] force_b_y,
  output logic [47:0] force_b_z,
  output logic [47:0] force_c_x,
  output logic [47:0] force_c_y,
  output logic [47:0] force_c_z,
  output logic [47:0] spring_energy,
  output logic [47:0] tension,
  output logic        zero_length
);

  logic ce;
  logic fr_v, sq_v, dv_v;
  logic [65:0] fr_sum;
  bshf_geo_t fr_geo, sq_geo, dv_geo;
  logic [32:0] sq_len, dv_len;
  logic [2:0][30:0] dv_u;
  logic [2:0][47:0] fa, fb, fc;

  assign ce = !(out_valid && out_stall);
  assign in_stall = !ce;

  bshf_front u_front (
    .clk   (clk),
    .rst   (rst),
    .ce    (ce),
    .in_v  (in_valid),
    .a     ({bead_a_z, bead_a_y, bead_a_x}),
    .b     ({bead_b_z, bead_b_y, bead_b_x}),
    .c     ({bead_c_z, bead_c_y, bead_c_x}),
    .bpos  (branch_position),
    .k     (stiffness),
    .l0    (rest_length),
    .out_v (fr_v),
    .sum   (fr_sum),
    .geo   (fr_geo)
  );

  bshf_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_v    (fr_v),
    .rad     (fr_sum),
    .in_geo  (fr_geo),
    .out_v   (sq_v),
    .len     (sq_len),
    .out_geo (sq_geo)
  );

  bshf_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_v    (sq_v),
    .in_len  (sq_len),
    .in_geo  (sq_geo),
    .out_v   (dv_v),
    .out_len (dv_len),
    .u       (dv_u),
    .out_geo (dv_geo)
  );

  bshf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_v    (dv_v),
    .len     (dv_len),
    .u       (dv_u),
    .geo     (dv_geo),
    .out_v   (out_valid),
    .fa      (fa),
    .fb      (fb),
    .fc      (fc),
    .energy  (spring_energy),
    .tension (tension),
    .zero    (zero_length)
  );

  assign force_a_x = fa[0];
  assign force_a_y = fa[1];
  assign force_a_z = fa[2];
  assign force_b_x = fb[0];
  assign force_b_y = fb[1];
  assign force_b_z = fb[2];
  assign force_c_x = fc[0];
  assign force_c_y = fc[1];
  assign force_c_z = fc[2];

endmodule

FILE: rtl/bshf_checker.sv
`include "branch_stretch_harmonic_force_unit_defines.svh"

module bshf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] force_a_x,
  input logic [47:0] force_b_x,
  input logic [47:0] force_c_x,
  input logic [47:0] tension,
  input logic        zero_length
);

  `BSHF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "Stalled result was dropped.")
  `BSHF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(tension) && $stable(force_c_x), "Stalled result changed.")
  `BSHF_ASSERT_SAME(a_in_stall, 1'b1, in_stall == (out_valid && out_stall), "Input stall does not follow the output stall.")
  `BSHF_ASSERT_SAME(a_zero_force, out_valid && zero_length, (force_a_x == 48'd0) && (force_b_x == 48'd0) && (force_c_x == 48'd0), "Force is nonzero at zero length.")

endmodule

bind branch_stretch_harmonic_force_unit bshf_checker u_bshf_checker (.*);

FILE: tb/sv/tb_top.sv
module tb_top;
  import bshf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [16:0] pos;
    logic [31:0] k;
    logic [30:0] l0;
  } branch_item_t;

  typedef struct {
    logic [47:0] v[12];
  } force_item_t;

  localparam int NUM_FIELDS = 12;
  localparam int ZL_IDX = 11;
  localparam int LONG_HOLD = 300;

  function automatic logic signed [47:0] round_scale(input logic [63:0] a, input logic [63:0] b,
                                                     input int sh, input bit neg);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1));
    full = full >> sh;
    if (neg) begin
      if (full >= 128'h8000_0000_0000) return SMIN48;
      return -$signed(full[47:0]);
    end
    if (full > 128'h7FFF_FFFF_FFFF) return SMAX48;
    return $signed(full[47:0]);
  endfunction

  function automatic force_item_t predict_forces(input branch_item_t it);
    force_item_t r;
    longint pv, wa, num, s;
    longint co[3][3];
    longint d[3];
    logic [63:0] m[3];
    logic [127:0] sumsq, full;
    logic [63:0] len, cand, sm, u, tm, gm;
    logic signed [47:0] t, g;
    sumsq = 0;
    len = 0;
    pv = (it.pos > ONE_Q16) ? 65536 : longint'(it.pos);
    wa = 65536 - pv;
    co[0] = '{longint'($signed(it.ax)), longint'($signed(it.bx)), longint'($signed(it.cx))};
    co[1] = '{longint'($signed(it.ay)), longint'($signed(it.by)), longint'($signed(it.cy))};
    co[2] = '{longint'($signed(it.az)), longint'($signed(it.bz)), longint'($signed(it.cz))};
    for (int i = 0; i < 3; i++) begin
      num = co[i][2] * 65536 - (wa * co[i][0] + pv * co[i][1]);
      d[i] = (num + 32768) >>> 16;
      m[i] = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
      sumsq = sumsq + {64'd0, m[i]} * {64'd0, m[i]};
    end
    for (int b = 33; b >= 0; b--) begin
      cand = len | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= sumsq) len = cand;
    end
    s = longint'(len) - longint'(it.l0);
    sm = (s < 0) ? 64'(-s) : 64'(s);
    t = round_scale(64'(it.k), sm, 16, s < 0);
    full = ({64'd0, sm} * {64'd0, sm}) * {96'd0, it.k};
    full = (full + (128'd1 << 32)) >> 33;
    r.v[9] = (full > 128'hFFFF_FFFF_FFFF) ? UMAX48 : full[47:0];
    r.v[10] = t;
    tm = t[47] ? 64'(-64'(t)) : 64'(t);
    if (len == 0) begin
      for (int i = 0; i < 9; i++) r.v[i] = '0;
      r.v[ZL_IDX] = 48'd1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        u = (m[i] << 30) / len;
        g = round_scale(tm, u, 30, t[47] != (d[i] < 0));
        gm = g[47] ? 64'(-64'(g)) : 64'(g);
        r.v[i] = round_scale(gm, 64'(wa), 16, g[47]);
        r.v[3 + i] = round_scale(gm, 64'(pv), 16, g[47]);
        r.v[6 + i] = (g == SMIN48) ? SMAX48 : -g;
      end
      r.v[ZL_IDX] = 48'd0;
    end
    return r;
  endfunction

  class force_scoreboard;
    force_item_t pending_forces[$];
    int errors;
    int checked;
    string names[NUM_FIELDS] = '{"force_a_x", "force_a_y", "force_a_z", "force_b_x",
      "force_b_y", "force_b_z", "force_c_x", "force_c_y", "force_c_z", "spring_energy",
      "tension", "zero_length"};

    function void note_input(input branch_item_t it);
      pending_forces.push_back(predict_forces(it));
    endfunction

    function void check_result(input force_item_t act);
      force_item_t exp_r;
      checked++;
      if (pending_forces.size() == 0) begin
        $display("%0t: result transfer with nothing pending", $time);
        errors++;
        return;
      end
      exp_r = pending_forces.pop_front();
      for (int i = 0; i < NUM_FIELDS; i++)
        if (exp_r.v[i] !== act.v[i]) begin
          $display("%0t: %s expected %h actual %h", $time, names[i], exp_r.v[i], act.v[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [31:0] bead_a_x, bead_a_y, bead_a_z, bead_b_x, bead_b_y, bead_b_z;
  logic [31:0] bead_c_x, bead_c_y, bead_c_z, stiffness;
  logic [16:0] branch_position;
  logic [30:0] rest_length;
  logic [47:0] force_a_x, force_a_y, force_a_z, force_b_x, force_b_y, force_b_z;
  logic [47:0] force_c_x, force_c_y, force_c_z, spring_energy, tension;
  logic zero_length;

  force_scoreboard sb = new();
  bit quiet;
  bit hold_req;
  int n_sent;
  int n_zero;

  branch_stretch_harmonic_force_unit i_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_top: errors");
    $finish;
  end

  task automatic send_item(input branch_item_t it);
    bead_a_x = it.ax; bead_a_y = it.ay; bead_a_z = it.az;
    bead_b_x = it.bx; bead_b_y = it.by; bead_b_z = it.bz;
    bead_c_x = it.cx; bead_c_y = it.cy; bead_c_z = it.cz;
    branch_position = it.pos; stiffness = it.k; rest_length = it.l0;
    in_valid = 1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(it);
    n_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic branch_item_t rand_item();
    branch_item_t it;
    it.ax = rand_coord(); it.ay = rand_coord(); it.az = rand_coord();
    it.bx = rand_coord(); it.by = rand_coord(); it.bz = rand_coord();
    it.cx = rand_coord(); it.cy = rand_coord(); it.cz = rand_coord();
    case ($urandom_range(0, 9))
      0: it.pos = 17'd0;
      1: it.pos = ONE_Q16;
      2: it.pos = 17'($urandom_range(65537, 131071));
      default: it.pos = 17'($urandom_range(0, 65536));
    endcase
    if ($urandom_range(0, 15) == 0) begin
      it.cx = it.ax; it.cy = it.ay; it.cz = it.az; it.pos = 17'd0;
    end
    it.k = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 22);
    it.l0 = ($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 23));
    return it;
  endfunction

  initial begin
    branch_item_t it;
    rst = 1; in_valid = 0;
    bead_a_x = 0; bead_a_y = 0; bead_a_z = 0; bead_b_x = 0; bead_b_y = 0; bead_b_z = 0;
    bead_c_x = 0; bead_c_y = 0; bead_c_z = 0; branch_position = 0; stiffness = 0;
    rest_length = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    it = '{default: '0};
    send_item(it);
    it.k = 32'hFFFF_FFFF; it.l0 = 31'h7FFF_FFFF;
    send_item(it);
    it = '{ax: 32'h8000_0000, ay: 32'h8000_0000, az: 32'h8000_0000,
           bx: 32'h7FFF_FFFF, by: 32'h7FFF_FFFF, bz: 32'h7FFF_FFFF,
           cx: 32'h7FFF_FFFF, cy: 32'h7FFF_FFFF, cz: 32'h7FFF_FFFF,
           pos: 17'd0, k: 32'hFFFF_FFFF, l0: 31'd0};
    send_item(it);
    it.pos = ONE_Q16;
    send_item(it);
    it.pos = 17'h1FFFF; it.cx = 32'h8000_0000;
    send_item(it);
    it.pos = 17'd32768; it.l0 = 31'h7FFF_FFFF;
    send_item(it);
    it = '{ax: 32'h0, ay: 32'h0, az: 32'h0, bx: 32'h0001_0000, by: 32'h0, bz: 32'h0,
           cx: 32'h0, cy: 32'h0003_0000, cz: 32'h0004_0000,
           pos: 17'd32768, k: 32'h0001_0000, l0: 31'h0002_0000};
    send_item(it);
    it.k = 32'h0000_0001; it.l0 = 31'h0000_0001;
    send_item(it);
    it.cy = 32'h0; it.cz = 32'h0; it.cx = 32'h0000_8000;
    send_item(it);
    it.cx = 32'h0000_0001; it.pos = 17'd1;
    send_item(it);
    it = '{ax: 32'hFFFF_FFFF, ay: 32'h1, az: 32'h0, bx: 32'h1, by: 32'hFFFF_FFFF, bz: 32'h0,
           cx: 32'h0, cy: 32'h0, cz: 32'h0, pos: 17'd32768, k: 32'hFFFF_FFFF, l0: 31'd5};
    send_item(it);
    it = '{ax: 32'h1234_5678, ay: 32'h8765_4321, az: 32'h0F0F_0F0F,
           bx: 32'h1234_5678, by: 32'h8765_4321, bz: 32'h0F0F_0F0F,
           cx: 32'h1234_5678, cy: 32'h8765_4321, cz: 32'h0F0F_0F0F,
           pos: 17'd12345, k: 32'h0010_0000, l0: 31'h0001_0000};
    send_item(it);
    it.pos = 17'h1FFFF; it.ax = 32'h0; it.k = 32'h0;
    send_item(it);

    for (int n = 0; n < 1200; n++) begin
      if (n == 400) hold_req = 1;
      if (n == 700) begin
        in_valid = 0;
        while (sb.pending_forces.size() != 0) @(negedge clk);
      end
      if (n == 1000) quiet = 1;
      send_item(rand_item());
    end
    in_valid = 0;
    while (sb.pending_forces.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d branch items, checked %0d results, %0d with zero length.",
             n_sent, sb.checked, n_zero);
    $display("Covered extreme coordinates, clamped positions, saturation and long stalls.");
    if (sb.errors == 0 && sb.pending_forces.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 0;
        out_stall = 1;
        stall_left = LONG_HOLD;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall = 1;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_stall = 0;
      end
    end
  end

  always @(posedge clk) begin
    force_item_t act;
    if (!rst && out_valid && !out_stall) begin
      act.v = '{force_a_x, force_a_y, force_a_z, force_b_x, force_b_y, force_b_z,
                force_c_x, force_c_y, force_c_z, spring_energy, tension, 48'(zero_length)};
      if (zero_length) n_zero++;
      sb.check_result(act);
    end
  end

endmodule
